// ===== sv/lzss_pkg.sv =====
// ----------------------------------------------------------------------------
// lzss_pkg
// Shared types and constants of the LZSS stream decoder: window geometry,
// token phases, sequencer states and the window access request.
// ----------------------------------------------------------------------------
package lzss_pkg;

	localparam int WIN_DEPTH = 4096;
	localparam int WIN_AW    = $clog2(WIN_DEPTH);
	localparam int FILL_W    = WIN_AW + 1;
	localparam int MAX_MATCH = 18;

	localparam logic [WIN_AW-1:0] WP_INIT   = WIN_AW'(WIN_DEPTH - MAX_MATCH);
	localparam logic [7:0]        SPACE     = 8'h20;
	localparam logic [7:0]        FLAG_FILL = 8'hff;

	typedef enum logic [1:0] {
		PH_TOKEN     = 2'd0,
		PH_FLAG_DONE = 2'd1,
		PH_MATCH2    = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		TK_NONE,
		TK_LIT,
		TK_MATCH
	} tok_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LIT,
		ST_COPY
	} state_t;

	typedef struct packed {
		logic              rd_en;
		logic [WIN_AW-1:0] rd_addr;
		logic              wr_en;
		logic [7:0]        wr_data;
		logic              clear;
	} win_req_t;

endpackage

// ===== sv/lzss_stream_decoder_core.sv =====
// ----------------------------------------------------------------------------
// lzss_stream_decoder_core
// LZSS decoder with a 4096-byte history window, one compressed byte per beat.
// ----------------------------------------------------------------------------
// A flag byte or the first byte of a match gives no output; input stays ready.
// A literal is accepted and then sent as one output beat. The second byte of
// a match starts a copy of L bytes (MATCH_BIAS + 1 up to MATCH_BIAS + 16): the
// accept, the first window read, then one output beat per cycle, set by the
// single read port of the window RAM and the copy address counter, as long as
// out_ready stays high. No new byte is taken until the item has been emitted.
// The window needs no clearing pass: a fill count marks what has been written
// since reset or the last final byte, and everything else reads as a space.
module lzss_stream_decoder_core #(
	parameter int MATCH_BIAS = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] code_byte,
	input  logic       final_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] plain_byte,
	output logic       run_end
);

	localparam int LEN_W = $clog2(15 + MATCH_BIAS + 2);

	lzss_pkg::state_t            state_q, state_n;
	lzss_pkg::phase_t            phase_q, phase_n;
	lzss_pkg::tok_kind_t         kind;
	lzss_pkg::win_req_t          win_req;
	logic [15:0]                 tok_bits_q, tok_bits_n;
	logic [15:0]                 shifted;
	logic [7:0]                  off_low_q, off_low_n;
	logic [7:0]                  lit_q;
	logic                        final_q;
	logic [lzss_pkg::WIN_AW-1:0] rd_addr_q;
	logic [LEN_W-1:0]            issue_left_q;
	logic [LEN_W-1:0]            emit_left_q;
	logic [LEN_W-1:0]            match_len;
	logic                        pend_q;
	logic                        start_tok;
	logic                        tok_bit;
	logic                        accept;
	logic                        out_free;
	logic                        emit_go;
	logic                        emit_last;
	logic [7:0]                  emit_byte;
	logic [7:0]                  win_data;
	logic                        rd_go;
	logic                        clear;
	logic                        out_valid_q;
	logic [7:0]                  out_byte_q;
	logic                        out_end_q;

	assign in_ready   = (state_q == lzss_pkg::ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign out_free   = !out_valid_q || out_ready;
	assign out_valid  = out_valid_q;
	assign plain_byte = out_byte_q;
	assign run_end    = out_end_q;
	assign match_len  = LEN_W'(code_byte[3:0]) + LEN_W'(MATCH_BIAS + 1);

	// Token parsing for the byte at the input.
	always_comb begin
		tok_bits_n = tok_bits_q;
		phase_n    = phase_q;
		off_low_n  = off_low_q;
		kind       = lzss_pkg::TK_NONE;
		start_tok  = 1'b0;
		tok_bit    = tok_bits_q[0];
		shifted    = {1'b0, tok_bits_q[15:1]};
		case (phase_q)
			lzss_pkg::PH_FLAG_DONE: begin
				start_tok = 1'b1;
			end
			lzss_pkg::PH_MATCH2: begin
				kind    = lzss_pkg::TK_MATCH;
				phase_n = lzss_pkg::PH_TOKEN;
			end
			default: begin
				// Ones above the flag byte run out after eight tokens.
				if (!shifted[8]) begin
					tok_bits_n = {lzss_pkg::FLAG_FILL, code_byte};
					phase_n    = lzss_pkg::PH_FLAG_DONE;
				end else begin
					tok_bits_n = shifted;
					start_tok  = 1'b1;
					tok_bit    = shifted[0];
				end
			end
		endcase
		if (start_tok) begin
			if (tok_bit) begin
				kind    = lzss_pkg::TK_LIT;
				phase_n = lzss_pkg::PH_TOKEN;
			end else begin
				off_low_n = code_byte;
				phase_n   = lzss_pkg::PH_MATCH2;
			end
		end
	end

	// Sequencer: next state, window requests and the output beat.
	always_comb begin
		state_n   = state_q;
		emit_go   = 1'b0;
		emit_last = 1'b0;
		emit_byte = lit_q;
		rd_go     = 1'b0;
		clear     = 1'b0;
		case (state_q)
			lzss_pkg::ST_IDLE: begin
				if (accept) begin
					case (kind)
						lzss_pkg::TK_LIT:   state_n = lzss_pkg::ST_LIT;
						lzss_pkg::TK_MATCH: state_n = lzss_pkg::ST_COPY;
						default:            clear = final_byte;
					endcase
				end
			end
			lzss_pkg::ST_LIT: begin
				emit_go   = out_free;
				emit_last = 1'b1;
				if (emit_go) begin
					state_n = lzss_pkg::ST_IDLE;
					clear   = final_q;
				end
			end
			lzss_pkg::ST_COPY: begin
				emit_byte = win_data;
				emit_go   = pend_q && out_free;
				emit_last = (emit_left_q == LEN_W'(1));
				rd_go     = (issue_left_q != '0) && (!pend_q || emit_go);
				if (emit_go && emit_last) begin
					state_n = lzss_pkg::ST_IDLE;
					clear   = final_q;
				end
			end
			default: begin
				state_n = lzss_pkg::ST_IDLE;
			end
		endcase
	end

	assign win_req.rd_en   = rd_go;
	assign win_req.rd_addr = rd_addr_q;
	assign win_req.wr_en   = emit_go;
	assign win_req.wr_data = emit_byte;
	assign win_req.clear   = clear;

	lzss_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (win_req),
		.rd_data (win_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lzss_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_bits_q   <= '0;
			phase_q      <= lzss_pkg::PH_TOKEN;
			off_low_q    <= '0;
			final_q      <= 1'b0;
			issue_left_q <= '0;
			emit_left_q  <= '0;
			pend_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				final_q <= final_byte;
				if (final_byte) begin
					tok_bits_q <= '0;
					phase_q    <= lzss_pkg::PH_TOKEN;
					off_low_q  <= '0;
				end else begin
					tok_bits_q <= tok_bits_n;
					phase_q    <= phase_n;
					off_low_q  <= off_low_n;
				end
			end
			if (accept && kind == lzss_pkg::TK_MATCH) begin
				issue_left_q <= match_len;
				emit_left_q  <= match_len;
				pend_q       <= 1'b0;
			end else begin
				if (rd_go) begin
					issue_left_q <= issue_left_q - 1'b1;
				end
				if (emit_go && state_q == lzss_pkg::ST_COPY) begin
					emit_left_q <= emit_left_q - 1'b1;
				end
				if (rd_go) begin
					pend_q <= 1'b1;
				end else if (emit_go) begin
					pend_q <= 1'b0;
				end
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lit_q <= code_byte;
		end
		if (accept && kind == lzss_pkg::TK_MATCH) begin
			rd_addr_q <= {code_byte[7:4], off_low_q};
		end else if (rd_go) begin
			rd_addr_q <= rd_addr_q + 1'b1;
		end
		if (emit_go) begin
			out_byte_q <= emit_byte;
			out_end_q  <= emit_last;
		end
	end

	// A byte is never pushed into an output register that still holds a beat.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(emit_go && out_valid_q && !out_ready))
		else $error("output beat overwritten before it was taken");

	// During a copy at most one fetched byte waits to be emitted.
	a_copy_balance: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lzss_pkg::ST_COPY) |->
		(emit_left_q == issue_left_q + LEN_W'(pend_q)))
		else $error("copy read and emit counters out of step");

	// A copy in progress always has bytes left to emit.
	a_copy_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lzss_pkg::ST_COPY) |-> (emit_left_q != '0))
		else $error("copy state with nothing left to emit");

	// The last byte of an item returns the sequencer to idle.
	a_end_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_go && emit_last) |=> (state_q == lzss_pkg::ST_IDLE))
		else $error("sequencer did not return to idle after the last byte");

endmodule

// ===== sv/lzss_ram.sv =====
// ----------------------------------------------------------------------------
// lzss_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lzss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/lzss_window.sv =====
// ----------------------------------------------------------------------------
// lzss_window
// History window: RAM, write pointer, fill count and same-cycle bypass.
// Entries not yet written since the last clear read back as spaces.
// ----------------------------------------------------------------------------
module lzss_window (
	input  logic                clk,
	input  logic                arst_n,
	input  lzss_pkg::win_req_t  req,
	output logic [7:0]          rd_data
);

	logic [lzss_pkg::WIN_AW-1:0] wp_q;
	logic [lzss_pkg::FILL_W-1:0] fill_q;
	logic [lzss_pkg::WIN_AW-1:0] rel_addr;
	logic                        in_fill;
	logic [7:0]                  ram_q;
	logic                        hit_q;
	logic                        vld_q;
	logic [7:0]                  byp_q;

	lzss_ram #(
		.WIDTH(8),
		.DEPTH(lzss_pkg::WIN_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (req.wr_en),
		.waddr (wp_q),
		.wdata (req.wr_data),
		.re    (req.rd_en),
		.raddr (req.rd_addr),
		.rdata (ram_q)
	);

	// Writes always run forward from WP_INIT, so the written entries form one
	// span starting there; its length is the fill count.
	assign rel_addr = req.rd_addr - lzss_pkg::WP_INIT;
	assign in_fill  = {1'b0, rel_addr} < fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= lzss_pkg::WP_INIT;
			fill_q <= '0;
		end else if (req.clear) begin
			wp_q   <= lzss_pkg::WP_INIT;
			fill_q <= '0;
		end else if (req.wr_en) begin
			wp_q <= wp_q + 1'b1;
			if (fill_q != lzss_pkg::FILL_W'(lzss_pkg::WIN_DEPTH)) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// The RAM returns old data when a read meets a write at the same address.
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			hit_q <= req.wr_en && (req.rd_addr == wp_q);
			byp_q <= req.wr_data;
			vld_q <= in_fill;
		end
	end

	assign rd_data = hit_q ? byp_q : (vld_q ? ram_q : lzss_pkg::SPACE);

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lzss_stream_decoder_core. A directed table of
// compressed bytes covers the window extremes, overlapping and wrapping
// copies, and streams that end inside a token. Random streams of flag groups
// then reuse recent history, with some noise mixed in. Every accepted input
// beat is run through a bit-accurate decoder model, and every output beat is
// checked against the oldest predicted byte.
// ----------------------------------------------------------------------------
module tb;

	localparam int MATCH_BIAS = 2;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [7:0] plain;
		logic       last;
	} plain_beat_t;

	typedef struct packed {
		logic [7:0] code;
		logic       fin;
		logic       typed;
		logic [4:0] n;
		logic [7:0] val;
	} dir_row_t;

	// Rows with typed set carry their results directly: n beats of val.
	localparam dir_row_t DIR_ROWS [26] = '{
		'{8'h00, 1'b0, 1'b1, 5'd0,  8'h00},
		'{8'h00, 1'b0, 1'b1, 5'd0,  8'h00},
		'{8'h00, 1'b0, 1'b1, 5'd3,  lzss_pkg::SPACE},
		'{8'hff, 1'b0, 1'b1, 5'd0,  8'h00},
		'{8'hff, 1'b0, 1'b1, 5'd18, lzss_pkg::SPACE},
		'{8'h34, 1'b1, 1'b1, 5'd0,  8'h00},
		'{8'hff, 1'b0, 1'b1, 5'd0,  8'h00},
		'{8'h00, 1'b0, 1'b1, 5'd1,  8'h00},
		'{8'hff, 1'b0, 1'b1, 5'd1,  8'hff},
		'{8'h41, 1'b0, 1'b1, 5'd1,  8'h41},
		'{8'h42, 1'b0, 1'b1, 5'd1,  8'h42},
		'{8'h43, 1'b0, 1'b1, 5'd1,  8'h43},
		'{8'h44, 1'b0, 1'b1, 5'd1,  8'h44},
		'{8'h45, 1'b0, 1'b1, 5'd1,  8'h45},
		'{8'h80, 1'b0, 1'b1, 5'd1,  8'h80},
		'{8'h01, 1'b0, 1'b1, 5'd0,  8'h00},
		'{8'h7e, 1'b0, 1'b1, 5'd1,  8'h7e},
		'{8'hf6, 1'b0, 1'b0, 5'd0,  8'h00},
		'{8'hf2, 1'b0, 1'b0, 5'd0,  8'h00},
		'{8'hfe, 1'b0, 1'b0, 5'd0,  8'h00},
		'{8'hff, 1'b0, 1'b0, 5'd0,  8'h00},
		'{8'h00, 1'b0, 1'b0, 5'd0,  8'h00},
		'{8'h13, 1'b1, 1'b0, 5'd0,  8'h00},
		'{8'ha5, 1'b1, 1'b1, 5'd0,  8'h00},
		'{8'h55, 1'b0, 1'b1, 5'd0,  8'h00},
		'{8'h20, 1'b1, 1'b1, 5'd1,  lzss_pkg::SPACE}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] code_byte = 8'h00;
	logic       final_byte = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] plain_byte;
	logic       run_end;

	// Decoder model state.
	logic [7:0]       win_hist [lzss_pkg::WIN_DEPTH];
	logic [11:0]      win_wp;
	logic [15:0]      flag_reg;
	lzss_pkg::phase_t tok_ph;
	logic [7:0]       pend_lo;
	logic [7:0]       step_bytes [$];

	plain_beat_t pending_plain [$];

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	logic hold_req = 1'b0;
	int hold_left = 0;
	int idle_cycles = 0;
	int mismatches = 0;
	int beats_in = 0;
	int beats_out = 0;
	int n_streams = 0;
	int n_copies = 0;

	lzss_stream_decoder_core #(
		.MATCH_BIAS(MATCH_BIAS)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.code_byte (code_byte),
		.final_byte(final_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.plain_byte(plain_byte),
		.run_end   (run_end)
	);

	always #6 clk = ~clk;

	function automatic void clear_model();
		foreach (win_hist[i]) win_hist[i] = lzss_pkg::SPACE;
		win_wp = lzss_pkg::WP_INIT;
		flag_reg = '0;
		tok_ph = lzss_pkg::PH_TOKEN;
		pend_lo = '0;
	endfunction

	function automatic void emit_plain(input logic [7:0] b);
		win_hist[win_wp] = b;
		win_wp = win_wp + 12'd1;
		step_bytes.push_back(b);
	endfunction

	function automatic void start_token(input logic [7:0] c);
		if (flag_reg[0]) begin
			tok_ph = lzss_pkg::PH_TOKEN;
			emit_plain(c);
		end else begin
			pend_lo = c;
			tok_ph = lzss_pkg::PH_MATCH2;
		end
	endfunction

	// Decodes one compressed byte into step_bytes.
	function automatic void decode_step(input logic [7:0] c, input logic fin);
		logic [15:0] shifted;
		logic [11:0] pos;
		logic [11:0] rd;
		int len;
		step_bytes.delete();
		case (tok_ph)
			lzss_pkg::PH_FLAG_DONE: start_token(c);
			lzss_pkg::PH_MATCH2: begin
				pos = {c[7:4], pend_lo};
				len = int'(c[3:0]) + MATCH_BIAS + 1;
				// Bytes are read one at a time, so a copy can see its own output.
				for (int k = 0; k < len; k++) begin
					rd = pos + 12'(k);
					emit_plain(win_hist[rd]);
				end
				tok_ph = lzss_pkg::PH_TOKEN;
			end
			default: begin
				shifted = flag_reg >> 1;
				if (!shifted[8]) begin
					flag_reg = {lzss_pkg::FLAG_FILL, c};
					tok_ph = lzss_pkg::PH_FLAG_DONE;
				end else begin
					flag_reg = shifted;
					start_token(c);
				end
			end
		endcase
		if (fin)
			clear_model();
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatches++;
	endtask

	// Offers one byte and waits for its beat; call at a rising edge.
	task automatic send_beat(input logic [7:0] c, input logic fin,
			input logic typed = 1'b0, input logic [4:0] n = '0,
			input logic [7:0] val = '0);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		code_byte <= c;
		final_byte <= fin;
		do @(posedge clk); while (!in_ready);
		beats_in++;
		decode_step(c, fin);
		if (typed) begin
			for (int i = 0; i < n; i++)
				pending_plain.push_back('{val, i == n - 1});
		end else begin
			foreach (step_bytes[i])
				pending_plain.push_back('{step_bytes[i], i == step_bytes.size() - 1});
		end
	endtask

	task automatic go_quiet();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Flag groups with random tokens; most copies point into recent history.
	// A quarter of the streams end on an extra byte, which may cut a token off.
	task automatic send_stream(input int ntok);
		bit cut;
		logic [7:0] flags;
		logic [11:0] pos;
		logic [3:0] ln;
		cut = ($urandom_range(0, 3) == 0);
		flags = '0;
		for (int t = 0; t < ntok; t++) begin
			if (t % 8 == 0) begin
				flags = 8'($urandom_range(0, 255));
				send_beat(flags, 1'b0);
			end
			if (flags[t % 8]) begin
				send_beat(8'($urandom_range(0, 255)), !cut && t == ntok - 1);
			end else begin
				if ($urandom_range(0, 9) < 7)
					pos = win_wp - 12'($urandom_range(1, 24));
				else
					pos = 12'($urandom_range(0, lzss_pkg::WIN_DEPTH - 1));
				ln = 4'($urandom_range(0, 15));
				send_beat(pos[7:0], 1'b0);
				send_beat({pos[11:8], ln}, !cut && t == ntok - 1);
				n_copies++;
			end
		end
		if (cut)
			send_beat(8'($urandom_range(0, 255)), 1'b1);
		n_streams++;
	endtask

	task automatic send_noise(input int n);
		for (int i = 0; i < n; i++)
			send_beat(8'($urandom_range(0, 255)),
				i == n - 1 || $urandom_range(0, 7) == 0);
	endtask

	// Receiver: random stalls, plus one long hold-off on request.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_req && hold_left == 0) begin
			hold_req <= 1'b0;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		plain_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			beats_out++;
			if (pending_plain.size() == 0) begin
				report_mismatch($sformatf("unexpected beat plain_byte=%02h run_end=%0b",
					plain_byte, run_end));
			end else begin
				want = pending_plain.pop_front();
				if (plain_byte !== want.plain)
					report_mismatch($sformatf("beat %0d plain_byte %02h, want %02h",
						beats_out, plain_byte, want.plain));
				if (run_end !== want.last)
					report_mismatch($sformatf("beat %0d run_end %0b, want %0b",
						beats_out, run_end, want.last));
			end
		end
	end

	// Watchdog on cycles without any beat on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Watchdog: no beat for %0d cycles, %0d results outstanding",
					STALL_LIMIT, pending_plain.size());
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		clear_model();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		tx_idle_pct = 11;
		rx_idle_pct = 75;
		@(posedge clk);

		for (int i = 0; i < $size(DIR_ROWS); i++)
			send_beat(DIR_ROWS[i].code, DIR_ROWS[i].fin, DIR_ROWS[i].typed,
				DIR_ROWS[i].n, DIR_ROWS[i].val);

		while (beats_in < 70)
			send_stream($urandom_range(4, 24));

		// Long receiver hold-off while bytes keep coming, then let it drain.
		hold_req <= 1'b1;
		send_stream(24);
		send_stream(24);
		go_quiet();
		while (pending_plain.size() != 0) @(posedge clk);

		tx_idle_pct = 75;
		rx_idle_pct = 11;
		while (beats_in < 170)
			send_stream($urandom_range(4, 24));
		send_noise(16);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		while (beats_in < 225)
			send_stream($urandom_range(4, 24));

		go_quiet();
		while (pending_plain.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d compressed bytes in %0d random streams plus directed rows,",
			beats_in, n_streams);
		$display("%0d random copy tokens, %0d decoded bytes, %0d mismatches.",
			n_copies, beats_out, mismatches);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
